// ===== rtl/emrc_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// emrc_pkg
// Types, constants and helpers shared by the MAC rewrite classifier.
// -----------------------------------------------------------------------------
package emrc_pkg;

	localparam int unsigned MAC_W = 48;
	localparam int unsigned POS_W = 11;

	localparam logic [POS_W-1:0] POS_MAX = '1;

	// region starts
	localparam logic [POS_W-1:0] POS_DST     = 11'd0;
	localparam logic [POS_W-1:0] POS_SRC     = 11'd6;
	localparam logic [POS_W-1:0] POS_ARP_SND = 11'd22;
	localparam logic [POS_W-1:0] POS_CHADDR  = 11'd70;

	// last position of minimum lengths (length - 1)
	localparam logic [POS_W-1:0] LAST_MIN_DST  = 11'd5;
	localparam logic [POS_W-1:0] LAST_MIN_SRC  = 11'd11;
	localparam logic [POS_W-1:0] LAST_ARP      = 11'd41;
	localparam logic [POS_W-1:0] LAST_MIN_DHCP = 11'd281;

	localparam logic [7:0] BOOTPS_PORT = 8'h43;
	localparam logic [7:0] BOOTPC_PORT = 8'h44;

	typedef enum logic [0:0] {
		REG_HOST_MAC  = 1'b0,
		REG_GUEST_MAC = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_ARP   = 2'd1,
		CLS_DHCP  = 2'd2
	} frame_class_t;

	typedef struct packed {
		logic             patch_destination;
		logic             patch_source;
		logic             patch_arp_sender;
		logic             patch_client_hw;
		logic [MAC_W-1:0] replacement_mac;
		frame_class_t     frame_class;
	} decision_t;

	// byte k of a MAC, first byte in the top bits
	function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] mac, input logic [2:0] k);
		logic [7:0] r;
		unique case (k)
			3'd0: r = mac[47:40];
			3'd1: r = mac[39:32];
			3'd2: r = mac[31:24];
			3'd3: r = mac[23:16];
			3'd4: r = mac[15:8];
			3'd5: r = mac[7:0];
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	// byte inside a 6-byte region that differs from the MAC
	function automatic logic region_miss(input logic [POS_W-1:0] pos,
			input logic [POS_W-1:0] start, input logic [MAC_W-1:0] mac,
			input logic [7:0] b);
		logic [POS_W-1:0] off;
		logic             inside_r;
		off      = pos - start;
		inside_r = (pos >= start) && (off < 11'd6);
		return inside_r && (b != mac_byte(mac, off[2:0]));
	endfunction

endpackage

// ===== rtl/emrc_byte_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// emrc_byte_if
// Frame byte channel: one byte with direction flag and last-byte mark.
// -----------------------------------------------------------------------------
interface emrc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       outbound;
	logic       frame_end;

	modport source (output valid, output data_byte, output outbound, output frame_end,
		input ready);
	modport sink (input valid, input data_byte, input outbound, input frame_end,
		output ready);
endinterface

// ===== rtl/emrc_dec_if.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// emrc_dec_if
// Decision channel: patch flags, replacement MAC and frame class.
// -----------------------------------------------------------------------------
interface emrc_dec_if;
	logic        valid;
	logic        ready;
	logic        patch_destination;
	logic        patch_source;
	logic        patch_arp_sender;
	logic        patch_client_hw;
	logic [47:0] replacement_mac;
	logic [1:0]  frame_class;

	modport source (output valid, output patch_destination, output patch_source,
		output patch_arp_sender, output patch_client_hw, output replacement_mac,
		output frame_class, input ready);
	modport sink (input valid, input patch_destination, input patch_source,
		input patch_arp_sender, input patch_client_hw, input replacement_mac,
		input frame_class, output ready);
endinterface

// ===== rtl/ethernet_mac_rewrite_classifier_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ethernet_mac_rewrite_classifier_top
// Classifies an Ethernet frame byte by byte and emits one MAC rewrite
// decision per frame.
// -----------------------------------------------------------------------------
// Takes one frame byte per clock unless stalled, back to back, with frames
// following each other without gaps. Each byte is registered, then folded into
// the frame's match state; a frame's decision is loaded into the output
// register as its last byte leaves the input register. Input stalls only while
// a decision waits and the registered byte is a last byte. The user must write
// host_mac and guest_mac through cfg while idle; the block does not enforce it.
module ethernet_mac_rewrite_classifier_top
	import emrc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [MAC_W-1:0] cfg_data,
	emrc_byte_if.sink        byte_ch,
	emrc_dec_if.source       decision_ch
);

	logic [MAC_W-1:0] host_mac_q, guest_mac_q;

	logic       vld_s1;
	logic [7:0] byte_s1;
	logic       outb_s1;
	logic       end_s1;

	logic       advance;
	logic       load;
	decision_t  dec;
	decision_t  dec_q;
	logic       out_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_mac_q  <= '0;
			guest_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_HOST_MAC:  host_mac_q  <= cfg_data;
				REG_GUEST_MAC: guest_mac_q <= cfg_data;
				default: begin end
			endcase
		end
	end

	assign advance       = vld_s1 && (!end_s1 || !out_vld_q || decision_ch.ready);
	assign load          = advance && end_s1;
	assign byte_ch.ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			vld_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			byte_s1 <= byte_ch.data_byte;
			outb_s1 <= byte_ch.outbound;
			end_s1  <= byte_ch.frame_end;
		end
	end

	emrc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.outbound  (outb_s1),
		.frame_end (end_s1),
		.host_mac  (host_mac_q),
		.guest_mac (guest_mac_q),
		.decision  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (load) begin
			out_vld_q <= 1'b1;
		end else if (decision_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_q <= dec;
		end
	end

	assign decision_ch.valid             = out_vld_q;
	assign decision_ch.patch_destination = dec_q.patch_destination;
	assign decision_ch.patch_source      = dec_q.patch_source;
	assign decision_ch.patch_arp_sender  = dec_q.patch_arp_sender;
	assign decision_ch.patch_client_hw   = dec_q.patch_client_hw;
	assign decision_ch.replacement_mac   = dec_q.replacement_mac;
	assign decision_ch.frame_class       = dec_q.frame_class;

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_vld_q)
		else $error("decision load did not raise valid");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && end_s1 && out_vld_q && !decision_ch.ready) |-> !byte_ch.ready)
		else $error("byte taken while last byte is stalled");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(dec_q.patch_destination && dec_q.patch_source))
		else $error("destination and source patched in one frame");

	a_arp_patch: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && dec_q.patch_arp_sender) |-> (dec_q.frame_class == CLS_ARP))
		else $error("ARP sender patched on a non-ARP frame");

	a_chw_dhcp: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && dec_q.patch_client_hw) |-> (dec_q.frame_class == CLS_DHCP))
		else $error("client address patched on a non-DHCP frame");

endmodule

// ===== rtl/emrc_scan.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// emrc_scan
// Per-frame match state; folds in one byte per step and forms the decision
// for the last byte of a frame.
// -----------------------------------------------------------------------------
module emrc_scan
	import emrc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [7:0]       data_byte,
	input  logic             outbound,
	input  logic             frame_end,
	input  logic [MAC_W-1:0] host_mac,
	input  logic [MAC_W-1:0] guest_mac,
	output decision_t        decision
);

	logic [POS_W-1:0] pos_q;
	logic             dir_q;
	logic             fb_low_q;
	logic             dst_q, all1_q, src_q, arp_snd_q, chw_q, arp_ok_q, dhcp_ok_q, cookie_q;

	logic             outb, fb_low;
	logic             dst_n, all1_n, src_n, arp_snd_n, chw_n, arp_ok_n, dhcp_ok_n, cookie_n;
	logic             arp_hit, dhcp_hit, ck_hit;
	logic [7:0]       arp_exp, dhcp_exp, ck_exp;
	logic             is_arp, is_dhcp, lowbit;

	assign outb   = (pos_q == '0) ? outbound : dir_q;
	assign fb_low = (pos_q == '0) ? data_byte[0] : fb_low_q;

	always_comb begin
		arp_hit  = 1'b0;
		arp_exp  = 8'h00;
		dhcp_hit = 1'b0;
		dhcp_exp = 8'h00;
		ck_hit   = 1'b0;
		ck_exp   = 8'h00;
		unique case (pos_q)
			11'd12: begin
				arp_hit = 1'b1; arp_exp = 8'h08; dhcp_hit = 1'b1; dhcp_exp = 8'h08;
			end
			11'd13: begin
				arp_hit = 1'b1; arp_exp = 8'h06; dhcp_hit = 1'b1; dhcp_exp = 8'h00;
			end
			11'd14: begin
				arp_hit = 1'b1; arp_exp = 8'h00; dhcp_hit = 1'b1; dhcp_exp = 8'h45;
			end
			11'd15: begin arp_hit = 1'b1; arp_exp = 8'h01; end
			11'd16: begin arp_hit = 1'b1; arp_exp = 8'h08; end
			11'd17: begin arp_hit = 1'b1; arp_exp = 8'h00; end
			11'd18: begin arp_hit = 1'b1; arp_exp = 8'h06; end
			11'd19: begin arp_hit = 1'b1; arp_exp = 8'h04; end
			11'd23: begin dhcp_hit = 1'b1; dhcp_exp = 8'h11; end
			11'd34: begin dhcp_hit = 1'b1; dhcp_exp = 8'h00; end
			11'd35: begin
				dhcp_hit = 1'b1; dhcp_exp = outb ? BOOTPC_PORT : BOOTPS_PORT;
			end
			11'd36: begin dhcp_hit = 1'b1; dhcp_exp = 8'h00; end
			11'd37: begin
				dhcp_hit = 1'b1; dhcp_exp = outb ? BOOTPS_PORT : BOOTPC_PORT;
			end
			11'd43: begin dhcp_hit = 1'b1; dhcp_exp = 8'h01; end
			11'd44: begin dhcp_hit = 1'b1; dhcp_exp = 8'h06; end
			11'd278: begin ck_hit = 1'b1; ck_exp = 8'h63; end
			11'd279: begin ck_hit = 1'b1; ck_exp = 8'h82; end
			11'd280: begin ck_hit = 1'b1; ck_exp = 8'h53; end
			11'd281: begin ck_hit = 1'b1; ck_exp = 8'h63; end
			default: begin end
		endcase
	end

	assign dst_n     = dst_q     & ~region_miss(pos_q, POS_DST, host_mac, data_byte);
	assign all1_n    = all1_q    & ~((pos_q < 11'd6) && (data_byte != 8'hff));
	assign src_n     = src_q     & ~region_miss(pos_q, POS_SRC, guest_mac, data_byte);
	assign arp_snd_n = arp_snd_q & ~region_miss(pos_q, POS_ARP_SND, guest_mac, data_byte);
	assign chw_n     = chw_q     & ~region_miss(pos_q, POS_CHADDR,
		outb ? guest_mac : host_mac, data_byte);
	assign arp_ok_n  = arp_ok_q  & ~(arp_hit && (data_byte != arp_exp));
	assign dhcp_ok_n = dhcp_ok_q & ~(dhcp_hit && (data_byte != dhcp_exp));
	assign cookie_n  = cookie_q  & ~(ck_hit && (data_byte != ck_exp));

	assign is_arp  = (pos_q == LAST_ARP) && arp_ok_n;
	assign is_dhcp = (pos_q >= LAST_MIN_DHCP) && dhcp_ok_n && cookie_n;

	always_comb begin
		decision                 = '0;
		decision.replacement_mac = outb ? host_mac : guest_mac;
		decision.frame_class     = is_arp ? CLS_ARP : CLS_OTHER;
		lowbit                   = 1'b0;
		if (!outb) begin
			decision.patch_destination = (pos_q >= LAST_MIN_DST) && dst_n;
			lowbit = decision.patch_destination ? guest_mac[40] : fb_low;
			if (!lowbit && is_dhcp) begin
				decision.frame_class     = CLS_DHCP;
				decision.patch_client_hw = chw_n;
			end
		end else begin
			decision.patch_source = (pos_q >= LAST_MIN_SRC) && src_n;
			if (is_arp) begin
				decision.patch_arp_sender = arp_snd_n;
			end else if ((pos_q >= LAST_MIN_DST) && all1_n && is_dhcp) begin
				decision.frame_class     = CLS_DHCP;
				decision.patch_client_hw = chw_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			dir_q     <= 1'b0;
			fb_low_q  <= 1'b0;
			dst_q     <= 1'b1;
			all1_q    <= 1'b1;
			src_q     <= 1'b1;
			arp_snd_q <= 1'b1;
			chw_q     <= 1'b1;
			arp_ok_q  <= 1'b1;
			dhcp_ok_q <= 1'b1;
			cookie_q  <= 1'b1;
		end else if (step) begin
			if (frame_end) begin
				pos_q     <= '0;
				dir_q     <= 1'b0;
				fb_low_q  <= 1'b0;
				dst_q     <= 1'b1;
				all1_q    <= 1'b1;
				src_q     <= 1'b1;
				arp_snd_q <= 1'b1;
				chw_q     <= 1'b1;
				arp_ok_q  <= 1'b1;
				dhcp_ok_q <= 1'b1;
				cookie_q  <= 1'b1;
			end else begin
				if (pos_q != POS_MAX) begin
					pos_q <= pos_q + 11'd1;
				end
				dir_q     <= outb;
				fb_low_q  <= fb_low;
				dst_q     <= dst_n;
				all1_q    <= all1_n;
				src_q     <= src_n;
				arp_snd_q <= arp_snd_n;
				chw_q     <= chw_n;
				arp_ok_q  <= arp_ok_n;
				dhcp_ok_q <= dhcp_ok_n;
				cookie_q  <= cookie_n;
			end
		end
	end

endmodule
